>>> design/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

  // Fixed field widths.
  localparam int ANGLE_W    = 24;
  localparam int CMP_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 32;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF      = 10;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // The servo mapping angle*2000/180 reduces to angle*100/9.
  // The division by 9 is a multiplication by ceil(2^35/9) and a shift.
  localparam logic [MUL_W-1:0] DEG_SCALE   = 32'd100;
  localparam logic [MUL_W-1:0] RECIP_NINE  = 32'd3817748708;
  localparam int               RECIP_SHIFT = 35;
  localparam logic [CMP_W-1:0] CMP_OFFSET  = 12'd500;

  localparam int MID_DEG = 90;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd655;
  localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 24'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 24'd11796480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 3'd0,
    CFG_PAN_DIR  = 3'd1,
    CFG_TILT_DIR = 3'd2,
    CFG_PAN_MIN  = 3'd3,
    CFG_PAN_MAX  = 3'd4,
    CFG_TILT_MIN = 3'd5,
    CFG_TILT_MAX = 3'd6
  } cfg_reg_e;

endpackage

>>> design/ptt_in_if.sv
`timescale 1ns / 1ps

interface ptt_in_if import ptt_pkg::*; #(
  parameter int COORD_W = COORD_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;
  logic [COORD_W-1:0] spot_x;
  logic [COORD_W-1:0] spot_y;

  modport source (output valid, goal_x, goal_y, spot_x, spot_y, input ready);
  modport sink (input valid, goal_x, goal_y, spot_x, spot_y, output ready);
endinterface

>>> design/ptt_out_if.sv
`timescale 1ns / 1ps

interface ptt_out_if import ptt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMP_W-1:0]   pan_compare;
  logic [CMP_W-1:0]   tilt_compare;
  logic               pan_moved;
  logic               tilt_moved;
  logic [ANGLE_W-1:0] pan_angle;
  logic [ANGLE_W-1:0] tilt_angle;

  modport source (output valid, pan_compare, tilt_compare, pan_moved, tilt_moved,
                  pan_angle, tilt_angle, input ready);
  modport sink (input valid, pan_compare, tilt_compare, pan_moved, tilt_moved,
                pan_angle, tilt_angle, output ready);
endinterface

>>> design/ptt_cfg_if.sv
`timescale 1ns / 1ps

interface ptt_cfg_if import ptt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/pan_tilt_servo_tracker.sv
`timescale 1ns / 1ps
// A new input item is taken only while the block is idle, not before the last one is through.
// Each axis takes seven steps (gain product, candidate, limit test, clamp, scale, divide, offset),
// and three of them use the one shared 32x32 multiplier. A finished result waits in the output
// register while the next item is taken. A result that is still not taken holds the block in its
// last step. Reset (asynchronous, active low) loads the register defaults and sets both angles
// to 90 degrees; no clearing pass is needed.

module pan_tilt_servo_tracker import ptt_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_in_if.sink     in_i,
  ptt_out_if.source  out_o,
  ptt_cfg_if.sink    cfg_i
);

  localparam int POS_W  = (ANGLE_FRAC_BITS + 8 > ANGLE_W) ? ANGLE_FRAC_BITS + 8 : ANGLE_W;
  localparam int UP     = (ANGLE_FRAC_BITS > GAIN_FRAC) ? ANGLE_FRAC_BITS - GAIN_FRAC : 0;
  localparam int DN     = (ANGLE_FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - ANGLE_FRAC_BITS : 0;
  localparam int MAG_W  = MUL_W + UP;
  localparam int CAND_W = ((MAG_W > POS_W) ? MAG_W : POS_W) + 2;
  localparam int CMP_SH = RECIP_SHIFT + ANGLE_FRAC_BITS;

  localparam logic [MUL_W:0]   RND     = (MUL_W+1)'((64'(1) << DN) - 64'(1));
  localparam logic [POS_W-1:0] MID_POS = POS_W'(MID_DEG) << ANGLE_FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_CAND  = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_CLAMP = 9'b000010000,
    S_M100  = 9'b000100000,
    S_RECIP = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_q;
  logic               pan_dir_q, tilt_dir_q;
  logic [ANGLE_W-1:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;

  // Per-axis state and working registers (index 0 is pan, 1 is tilt).
  logic [POS_W-1:0]      pos_q [2];
  logic [COORD_BITS-1:0] err_mag_q [2];
  logic                  err_neg_q [2];
  logic [CMP_W-1:0]      cmp_q [2];
  logic                  moved_q [2];
  logic [2*MUL_W-1:0]    prod_q;
  logic [CAND_W-1:0]     cand_q;
  logic [ANGLE_W-1:0]    clamp_q;
  logic                  out_valid_q;

  logic                  in_fire, out_free;
  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic [ANGLE_W-1:0]    lo_sel, hi_sel;
  logic                  dir_sel, inc_neg, upd_ok;
  logic [MUL_W:0]        sum_rnd;
  logic [MAG_W-1:0]      mag;
  logic [CAND_W-1:0]     mag_ext, cand_d;
  logic [POS_W-1:0]      pos_sel, lo_pos, hi_pos;
  logic [ANGLE_W-1:0]    clamp_d;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign diff_x = {1'b0, in_i.goal_x} - {1'b0, in_i.spot_x};
  assign diff_y = {1'b0, in_i.goal_y} - {1'b0, in_i.spot_y};

  // Per-axis selection.
  assign lo_sel  = axis_q ? tilt_min_q : pan_min_q;
  assign hi_sel  = axis_q ? tilt_max_q : pan_max_q;
  assign dir_sel = axis_q ? tilt_dir_q : pan_dir_q;
  assign pos_sel = pos_q[axis_q];
  assign lo_pos  = POS_W'(lo_sel);
  assign hi_pos  = POS_W'(hi_sel);

  // Shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL: begin
        mul_a = MUL_W'(err_mag_q[axis_q]);
        mul_b = MUL_W'(gain_q);
      end
      S_M100: begin
        mul_a = MUL_W'(clamp_q);
        mul_b = DEG_SCALE;
      end
      S_RECIP: begin
        mul_a = prod_q[MUL_W-1:0];
        mul_b = RECIP_NINE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

  // A negative product rounds toward minus infinity when the angle has fewer
  // fraction bits than the gain, so its magnitude rounds up.
  assign sum_rnd = {1'b0, prod_q[MUL_W-1:0]} + (err_neg_q[axis_q] ? RND : '0);
  assign mag     = MAG_W'(sum_rnd >> DN) << UP;
  assign mag_ext = CAND_W'(mag);
  assign inc_neg = err_neg_q[axis_q] ^ ~dir_sel;
  assign cand_d  = CAND_W'(pos_sel) + (inc_neg ? (~mag_ext + CAND_W'(1)) : mag_ext);

  assign upd_ok = ($signed(CAND_W'(lo_sel)) < $signed(cand_q)) &&
                  ($signed(cand_q) < $signed(CAND_W'(hi_sel)));

  // Clamping tests the upper limit first.
  always_comb begin
    if (pos_sel > hi_pos) begin
      clamp_d = hi_sel;
    end else if (pos_sel < lo_pos) begin
      clamp_d = lo_sel;
    end else begin
      clamp_d = ANGLE_W'(pos_sel);
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MUL;
          axis_d  = 1'b0;
        end
      end
      S_MUL:   state_d = S_CAND;
      S_CAND:  state_d = S_UPD;
      S_UPD:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_M100;
      S_M100:  state_d = S_RECIP;
      S_RECIP: state_d = S_CMP;
      S_CMP: begin
        if (axis_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
          axis_d  = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q[0]    <= MID_POS;
      pos_q[1]    <= MID_POS;
      gain_q      <= GAIN_RST;
      pan_dir_q   <= 1'b1;
      tilt_dir_q  <= 1'b1;
      pan_min_q   <= ANGLE_MIN_RST;
      pan_max_q   <= ANGLE_MAX_RST;
      tilt_min_q  <= ANGLE_MIN_RST;
      tilt_max_q  <= ANGLE_MAX_RST;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_UPD && upd_ok) begin
        pos_q[axis_q] <= POS_W'(cand_q);
      end
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_GAIN:     gain_q     <= cfg_i.data[GAIN_W-1:0];
          CFG_PAN_DIR:  pan_dir_q  <= cfg_i.data[0];
          CFG_TILT_DIR: tilt_dir_q <= cfg_i.data[0];
          CFG_PAN_MIN:  pan_min_q  <= cfg_i.data[ANGLE_W-1:0];
          CFG_PAN_MAX:  pan_max_q  <= cfg_i.data[ANGLE_W-1:0];
          CFG_TILT_MIN: tilt_min_q <= cfg_i.data[ANGLE_W-1:0];
          CFG_TILT_MAX: tilt_max_q <= cfg_i.data[ANGLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_neg_q[0] <= diff_x[COORD_BITS];
      err_neg_q[1] <= diff_y[COORD_BITS];
      err_mag_q[0] <= diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      err_mag_q[1] <= diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    end
    if (state_q == S_MUL || state_q == S_M100 || state_q == S_RECIP) begin
      prod_q <= mul_p;
    end
    if (state_q == S_CAND) begin
      cand_q <= cand_d;
    end
    if (state_q == S_UPD) begin
      moved_q[axis_q] <= upd_ok;
    end
    if (state_q == S_CLAMP) begin
      clamp_q <= clamp_d;
    end
    if (state_q == S_CMP) begin
      cmp_q[axis_q] <= CMP_W'(prod_q >> CMP_SH) + CMP_OFFSET;
    end
    if (state_q == S_DONE && out_free) begin
      out_o.pan_compare  <= cmp_q[0];
      out_o.tilt_compare <= cmp_q[1];
      out_o.pan_moved    <= moved_q[0];
      out_o.tilt_moved   <= moved_q[1];
      out_o.pan_angle    <= pos_q[0][ANGLE_W-1:0];
      out_o.tilt_angle   <= pos_q[1][ANGLE_W-1:0];
    end
  end

  assign out_o.valid = out_valid_q;

  a_start_pan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MUL) && (axis_q == 1'b0))
    else $error("item did not start on the pan axis");

  a_hold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) && !upd_ok |=> $stable(pos_q[0]) && $stable(pos_q[1]))
    else $error("angle changed although the limit test failed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input taken while an item is in progress");

  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_free |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished item not moved to the output register");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptt_pkg::*;

  localparam int COORD_W       = COORD_BITS_DEF;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int LATENCY       = 16;
  localparam int MAX_CYCLES    = 600000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 120;
  localparam longint HALF_TURN = longint'(180) << ANGLE_FRAC_BITS_DEF;
  localparam logic [ANGLE_W-1:0] MID_ANGLE = ANGLE_W'(MID_DEG << ANGLE_FRAC_BITS_DEF);
  localparam logic [ANGLE_W-1:0] ANGLE_ALL_ONES = '1;

  typedef struct packed {
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [COORD_W-1:0] spot_x;
    logic [COORD_W-1:0] spot_y;
  } pixels_t;

  typedef struct packed {
    logic [CMP_W-1:0]   pan_compare;
    logic [CMP_W-1:0]   tilt_compare;
    logic               pan_moved;
    logic               tilt_moved;
    logic [ANGLE_W-1:0] pan_angle;
    logic [ANGLE_W-1:0] tilt_angle;
  } pose_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_LONG} sink_mode_e;

  class pose_scoreboard;
    logic [GAIN_W-1:0]  gain;
    logic               pan_dir;
    logic               tilt_dir;
    logic [ANGLE_W-1:0] pan_min, pan_max, tilt_min, tilt_max;
    logic [ANGLE_W-1:0] pan_pos, tilt_pos;
    pose_t              expected_poses[$];
    int                 errors;

    function new();
      gain     = GAIN_RST;
      pan_dir  = 1'b1;
      tilt_dir = 1'b1;
      pan_min  = ANGLE_MIN_RST;
      pan_max  = ANGLE_MAX_RST;
      tilt_min = ANGLE_MIN_RST;
      tilt_max = ANGLE_MAX_RST;
      pan_pos  = MID_ANGLE;
      tilt_pos = MID_ANGLE;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN:     gain     = data[GAIN_W-1:0];
        CFG_PAN_DIR:  pan_dir  = data[0];
        CFG_TILT_DIR: tilt_dir = data[0];
        CFG_PAN_MIN:  pan_min  = data[ANGLE_W-1:0];
        CFG_PAN_MAX:  pan_max  = data[ANGLE_W-1:0];
        CFG_TILT_MIN: tilt_min = data[ANGLE_W-1:0];
        CFG_TILT_MAX: tilt_max = data[ANGLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Gain and angle carry the same number of fraction bits, so the product
    // is already in angle units and needs no rounding.
    function longint increment(logic [COORD_W-1:0] goal, logic [COORD_W-1:0] spot,
                               logic dir);
      longint prod;
      prod = (longint'(goal) - longint'(spot)) * longint'(gain);
      return dir ? prod : -prod;
    endfunction

    // A candidate angle is taken only when it lies strictly inside the limits.
    function logic move_axis(inout logic [ANGLE_W-1:0] pos, input longint inc,
                             input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] hi);
      longint cand;
      cand = longint'(pos) + inc;
      if (longint'(lo) < cand && cand < longint'(hi)) begin
        pos = ANGLE_W'(cand);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [CMP_W-1:0] servo_compare(logic [ANGLE_W-1:0] angle,
                                             logic [ANGLE_W-1:0] lo,
                                             logic [ANGLE_W-1:0] hi);
      longint a;
      a = longint'(angle);
      if (angle > hi) a = longint'(hi);
      else if (angle < lo) a = longint'(lo);
      return CMP_W'(a * 2000 / HALF_TURN + 500);
    endfunction

    function void take_pixels(pixels_t px);
      pose_t p;
      p.pan_moved  = move_axis(pan_pos, increment(px.goal_x, px.spot_x, pan_dir),
                               pan_min, pan_max);
      p.tilt_moved = move_axis(tilt_pos, increment(px.goal_y, px.spot_y, tilt_dir),
                               tilt_min, tilt_max);
      p.pan_compare  = servo_compare(pan_pos, pan_min, pan_max);
      p.tilt_compare = servo_compare(tilt_pos, tilt_min, tilt_max);
      p.pan_angle    = pan_pos;
      p.tilt_angle   = tilt_pos;
      expected_poses.push_back(p);
    endfunction

    function void check_field(string name, logic [ANGLE_W-1:0] exp,
                              logic [ANGLE_W-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_pose(pose_t got);
      pose_t exp;
      if (expected_poses.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        errors++;
        return;
      end
      exp = expected_poses.pop_front();
      check_field("pan_compare", exp.pan_compare, got.pan_compare);
      check_field("tilt_compare", exp.tilt_compare, got.tilt_compare);
      check_field("pan_moved", exp.pan_moved, got.pan_moved);
      check_field("tilt_moved", exp.tilt_moved, got.tilt_moved);
      check_field("pan_angle", exp.pan_angle, got.pan_angle);
      check_field("tilt_angle", exp.tilt_angle, got.tilt_angle);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   burst_left = 0;

  pose_scoreboard sb = new();

  ptt_in_if #(.COORD_W(COORD_W)) in_if ();
  ptt_out_if                     out_if ();
  ptt_cfg_if                     cfg_if ();

  pan_tilt_servo_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    pose_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.pan_compare  = out_if.pan_compare;
      got.tilt_compare = out_if.tilt_compare;
      got.pan_moved    = out_if.pan_moved;
      got.tilt_moved   = out_if.tilt_moved;
      got.pan_angle    = out_if.pan_angle;
      got.tilt_angle   = out_if.tilt_angle;
      sb.check_pose(got);
    end
  end

  // The receiver switches between stall patterns every so often.
  sink_mode_e sink_mode  = SINK_OPEN;
  int         sink_left  = 0;
  int         hold_left  = 0;
  logic       hold_level = 1'b1;

  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 200);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:   out_if.ready <= 1'b1;
      SINK_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      SINK_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_level = ~hold_level;
          hold_left  = $urandom_range(1, 40);
        end
        hold_left--;
        out_if.ready <= hold_level;
      end
    endcase
  end

  function automatic pixels_t px_of(input int gx, input int gy, input int sx, input int sy);
    pixels_t px;
    px.goal_x = COORD_W'(gx);
    px.goal_y = COORD_W'(gy);
    px.spot_x = COORD_W'(sx);
    px.spot_y = COORD_W'(sy);
    return px;
  endfunction

  function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] goal);
    int c;
    c = int'(goal) + int'($urandom_range(0, 128)) - 64;
    if (c < 0) c = 0;
    if (c > COORD_MAX) c = COORD_MAX;
    return COORD_W'(c);
  endfunction

  // Mostly a spot close to the target, so that small corrections get through
  // the limit test; the rest is spread over the whole frame.
  function automatic pixels_t random_pixels();
    pixels_t px;
    px.goal_x = COORD_W'($urandom);
    px.goal_y = COORD_W'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      px.spot_x = near(px.goal_x);
      px.spot_y = near(px.goal_y);
    end else begin
      px.spot_x = COORD_W'($urandom);
      px.spot_y = COORD_W'($urandom);
    end
    return px;
  endfunction

  task automatic send_pixels(pixels_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.goal_x <= px.goal_x;
    in_if.goal_y <= px.goal_y;
    in_if.spot_x <= px.spot_x;
    in_if.spot_y <= px.spot_y;
    do @(posedge clk_i); while (!in_if.ready);
    sb.take_pixels(px);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_poses.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [GAIN_W-1:0] gain, input logic pan_dir,
                             input logic tilt_dir,
                             input logic [ANGLE_W-1:0] pmin, input logic [ANGLE_W-1:0] pmax,
                             input logic [ANGLE_W-1:0] tmin, input logic [ANGLE_W-1:0] tmax);
    write_reg(CFG_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_PAN_DIR, CFG_DATA_W'(pan_dir));
    write_reg(CFG_TILT_DIR, CFG_DATA_W'(tilt_dir));
    write_reg(CFG_PAN_MIN, CFG_DATA_W'(pmin));
    write_reg(CFG_PAN_MAX, CFG_DATA_W'(pmax));
    write_reg(CFG_TILT_MIN, CFG_DATA_W'(tmin));
    write_reg(CFG_TILT_MAX, CFG_DATA_W'(tmax));
    cfg_if.valid <= 1'b0;
  endtask

  // Limits are either the full range, a window around the present angle, or
  // anything at all, which includes a lower limit above the upper one.
  function automatic void pick_limits(input logic [ANGLE_W-1:0] pos,
                                      output logic [ANGLE_W-1:0] lo,
                                      output logic [ANGLE_W-1:0] hi);
    int unsigned pick, span;
    pick = $urandom_range(0, 9);
    span = $urandom_range(1, 1 << 21);
    if (pick < 3) begin
      lo = ANGLE_MIN_RST;
      hi = ANGLE_MAX_RST;
    end else if (pick < 8) begin
      lo = (pos > span) ? ANGLE_W'(pos - span) : '0;
      span = $urandom_range(1, 1 << 21);
      hi = ((pos + span) < ANGLE_MAX_RST) ? ANGLE_W'(pos + span) : ANGLE_MAX_RST;
    end else begin
      lo = ANGLE_W'($urandom_range(0, ANGLE_MAX_RST));
      hi = ANGLE_W'($urandom_range(0, ANGLE_MAX_RST));
    end
  endfunction

  task automatic random_config();
    logic [GAIN_W-1:0]  g;
    logic [ANGLE_W-1:0] pmin, pmax, tmin, tmax;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) g = GAIN_W'($urandom_range(1, 2000));
    else if (pick < 7) g = GAIN_W'($urandom);
    else if (pick == 7) g = '0;
    else if (pick == 8) g = '1;
    else g = GAIN_RST;
    pick_limits(sb.pan_pos, pmin, pmax);
    pick_limits(sb.tilt_pos, tmin, tmax);
    load_config(g, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                pmin, pmax, tmin, tmax);
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.goal_x = '0;
    in_if.goal_y = '0;
    in_if.spot_x = '0;
    in_if.spot_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero error and the largest errors of either sign.
    send_pixels(px_of(512, 512, 512, 512));
    send_pixels(px_of(COORD_MAX, COORD_MAX, 0, 0));
    send_pixels(px_of(0, 0, COORD_MAX, COORD_MAX));
    send_pixels(px_of(0, 0, 0, 0));
    send_pixels(px_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pixels(px_of(700, 300, 200, 900));
    settle();

    // Full gain with the pan sign flipped: pan goes past 180 degrees, while
    // tilt starts below its new lower limit and is pulled inside.
    load_config('1, 1'b0, 1'b1, '0, ANGLE_ALL_ONES, ANGLE_W'(10000000), ANGLE_MAX_RST);
    send_pixels(px_of(0, 512, 100, 512));
    send_pixels(px_of(0, 592, 100, 512));
    settle();

    // Limits placed so that a candidate lands exactly on them.
    load_config(GAIN_W'(1000), 1'b1, 1'b1, '0, ANGLE_W'(sb.pan_pos + 5000),
                ANGLE_W'(sb.tilt_pos - 3000), ANGLE_MAX_RST);
    send_pixels(px_of(105, 100, 100, 103));
    send_pixels(px_of(104, 100, 100, 102));
    send_pixels(px_of(101, 100, 100, 101));
    settle();

    // Lower limit above the upper one on pan, both tilt limits at zero.
    load_config('0, 1'b1, 1'b0, ANGLE_W'(8000000), ANGLE_W'(2000000), '0, '0);
    send_pixels(px_of(COORD_MAX, 0, 0, COORD_MAX));
    send_pixels(px_of(300, 400, 500, 600));
    settle();

    // Zero gain with full limits: only an angle strictly inside moves.
    load_config('0, 1'b0, 1'b0, ANGLE_MIN_RST, ANGLE_MAX_RST, ANGLE_MIN_RST, ANGLE_MAX_RST);
    send_pixels(px_of(0, COORD_MAX, COORD_MAX, 0));
    settle();

    // A large negative step brings pan back below 180 degrees.
    load_config('1, 1'b1, 1'b1, ANGLE_MIN_RST, ANGLE_MAX_RST, ANGLE_MIN_RST, ANGLE_MAX_RST);
    send_pixels(px_of(80, 100, 100, 100));
    send_pixels(px_of(100, 100, 100, 100));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config();
      repeat (PHASE_ITEMS) send_pixels(random_pixels());
      settle();
    end

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
